// File: src/sbcd_pkg.sv
// ---------------------------------------------------------------------------
// sbcd_pkg - shared types and helpers for the signed binary to BCD converter
// Digit counts, the per-stage control word and nibble helpers used by the
// shift-and-add-3 cell chain and the output formatting.
// ---------------------------------------------------------------------------
`default_nettype none

package sbcd_pkg;

    localparam int MAG_W       = 64;                  // magnitude bits, one per cell
    localparam int NUM_DIGITS  = 20;                  // digits a 64-bit magnitude can need
    localparam int BCD_W       = 4 * NUM_DIGITS;      // packed BCD accumulator width
    localparam int WORD_DIGITS = 16;                  // digits per output word
    localparam int WORD_W      = 4 * WORD_DIGITS;     // output word width
    localparam int HI_USED_W   = BCD_W - WORD_W;      // live bits of the high word
    localparam logic [3:0] DIGIT_NINE = 4'd9;
    localparam logic [3:0] DIGIT_FIVE = 4'd5;
    localparam logic [3:0] DIGIT_ADJ  = 4'd3;

    // Control bits that travel with a word through the chain
    typedef struct packed {
        logic valid;
        logic wide;      // 32-digit format
        logic neg;       // input was negative
    } stage_ctl_t;

    // Add 3 to every digit that is 5 or more, ahead of the left shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        logic [3:0]       d;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = bcd[4*i +: 4];
            if (d >= DIGIT_FIVE)
                res[4*i +: 4] = d + DIGIT_ADJ;
        end
        return res;
    endfunction

    // Nines complement of every digit of a word
    function automatic logic [WORD_W-1:0] nines_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] res;
        for (int i = 0; i < WORD_DIGITS; i++)
            res[4*i +: 4] = DIGIT_NINE - w[4*i +: 4];
        return res;
    endfunction

    // True when every nibble of a word is a decimal digit
    function automatic logic word_is_bcd(input logic [WORD_W-1:0] w);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < WORD_DIGITS; i++)
            if (w[4*i +: 4] > DIGIT_NINE)
                ok = 1'b0;
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: src/signed_binary_to_packed_bcd_top.sv
// ---------------------------------------------------------------------------
// signed_binary_to_packed_bcd_top - signed 64-bit to packed BCD converter
// Converts the magnitude with a 64-cell shift-and-add-3 chain; negative
// values come out as nines complement digits, in 16- or 32-digit format.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata = value, tuser = operation
//  m_axis    out  m_axis_tvalid/tready        tdata = low_digits, high_digits
//
//  One word accepted per cycle while the output is not stalled.
//  Pipeline: input register, 64 chain cells (one per magnitude bit),
//  output register.
//  A stalled output word freezes the whole chain and drops s_axis_tready.
//  Reset clears all valid bits; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module signed_binary_to_packed_bcd_top
    import sbcd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [63:0]   s_axis_tdata,   // [63:0] value
    input  wire logic [0:0]    s_axis_tuser,   // [0] operation
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [127:0]       m_axis_tdata    // [63:0] low_digits, [127:64] high_digits
);

    logic adv;

    stage_ctl_t       ctl_chain [0:MAG_W];
    logic [MAG_W-1:0] mag_chain [0:MAG_W];
    logic [BCD_W-1:0] bcd_chain [0:MAG_W];

    stage_ctl_t       in_ctl_reg, in_ctl_next;
    logic [MAG_W-1:0] in_mag_reg, in_mag_next;

    logic             out_valid_reg;
    logic             out_wide_reg;
    logic [WORD_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [WORD_W-1:0] hi_raw;

    // Whole pipeline moves unless a finished word is held at the output
    assign adv           = !(out_valid_reg && !m_axis_tready);
    assign s_axis_tready = adv;

    // Input stage: sign and magnitude
    always_comb
    begin
        in_ctl_next.valid = s_axis_tvalid;
        in_ctl_next.wide  = s_axis_tuser[0];
        in_ctl_next.neg   = s_axis_tdata[63];
        in_mag_next       = s_axis_tdata[63] ? (MAG_W'(0) - s_axis_tdata) : s_axis_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctl_reg <= '0;
        end
        else if (adv)
        begin
            in_ctl_reg <= in_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_mag_reg <= in_mag_next;
        end
    end

    assign ctl_chain[0] = in_ctl_reg;
    assign mag_chain[0] = in_mag_reg;
    assign bcd_chain[0] = '0;

    // Chain of conversion cells, one per magnitude bit
    for (genvar k = 0; k < MAG_W; k++)
    begin : g_cell
        sbcd_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_ctl  (ctl_chain[k]),
            .in_mag  (mag_chain[k]),
            .in_bcd  (bcd_chain[k]),
            .out_ctl (ctl_chain[k+1]),
            .out_mag (mag_chain[k+1]),
            .out_bcd (bcd_chain[k+1])
        );
    end

    // Output formatting: nines complement and format select
    always_comb
    begin
        hi_raw  = {{(WORD_W-HI_USED_W){1'b0}}, bcd_chain[MAG_W][BCD_W-1:WORD_W]};
        lo_next = ctl_chain[MAG_W].neg ? nines_word(bcd_chain[MAG_W][WORD_W-1:0])
                                       : bcd_chain[MAG_W][WORD_W-1:0];
        if (!ctl_chain[MAG_W].wide)
            hi_next = '0;
        else if (ctl_chain[MAG_W].neg)
            hi_next = nines_word(hi_raw);
        else
            hi_next = hi_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_chain[MAG_W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            out_wide_reg <= ctl_chain[MAG_W].wide;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {hi_reg, lo_reg};

    // A valid word at the chain end reaches the output on the next advance
    a_chain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ctl_chain[MAG_W].valid) |=> m_axis_tvalid)
        else $error("chain word lost at output register");

    // 16-digit format leaves the high word at zero
    a_narrow_hi_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_wide_reg) |-> (hi_reg == '0))
        else $error("high digits not zero in 16-digit format");

    // Every output nibble is a decimal digit
    a_digits_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (word_is_bcd(lo_reg) && word_is_bcd(hi_reg)))
        else $error("output nibble is not a decimal digit");

    // Chain end holds a proper BCD accumulator
    a_chain_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_chain[MAG_W].valid |->
            (word_is_bcd(bcd_chain[MAG_W][WORD_W-1:0]) && word_is_bcd(hi_raw)))
        else $error("chain accumulator holds a non-decimal digit");

endmodule

`default_nettype wire

// File: src/sbcd_cell.sv
// ---------------------------------------------------------------------------
// sbcd_cell - one shift-and-add-3 step of the binary to BCD chain
// Adjusts the BCD accumulator, shifts in the top magnitude bit and registers
// the result for the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module sbcd_cell
    import sbcd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire stage_ctl_t        in_ctl,
    input  wire logic [MAG_W-1:0]  in_mag,
    input  wire logic [BCD_W-1:0]  in_bcd,
    output stage_ctl_t             out_ctl,
    output logic      [MAG_W-1:0]  out_mag,
    output logic      [BCD_W-1:0]  out_bcd
);

    stage_ctl_t       ctl_reg;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next, bcd_adj;

    // One double-dabble step
    always_comb
    begin
        bcd_adj  = bcd_adjust(in_bcd);
        bcd_next = {bcd_adj[BCD_W-2:0], in_mag[MAG_W-1]};
        mag_next = {in_mag[MAG_W-2:0], 1'b0};
    end

    // Control: valid cleared on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= in_ctl;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            bcd_reg <= bcd_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_mag = mag_reg;
    assign out_bcd = bcd_reg;

endmodule

`default_nettype wire
